### design/rtt_pkg.sv
// Shared codes, widths and types of the region transition tally.
`default_nettype none
package rtt_pkg;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 6;
    localparam int AIR_W   = 8;
    localparam int VALUE_W = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SEGMENT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MISS       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ_LEAVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ_ICPT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_MISS  = 3'd4;

    // medium codes
    localparam logic [AIR_W-1:0] MED_REGION   = 8'd0;
    localparam logic [AIR_W-1:0] MED_EXTERIOR = 8'd1;
    localparam logic [AIR_W-1:0] MED_ENGINE   = 8'd5;

    // what the medium tracker decides for one segment
    typedef struct packed {
        logic             tally;
        logic             no_source;
        logic [IDX_W-1:0] src;
    } t_decision;

endpackage
`default_nettype wire

### design/rtt_if.sv
// Handshake channels of the region transition tally: item beats in, result beats out.
`default_nettype none
interface rtt_in_if;
    logic                       valid;
    logic                       ready;
    logic [rtt_pkg::KIND_W-1:0] kind;
    logic                       new_ray;
    logic                       is_region;
    logic [rtt_pkg::IDX_W-1:0]  region_index;
    logic [rtt_pkg::AIR_W-1:0]  air_code;
    logic [rtt_pkg::IDX_W-1:0]  column_index;

    modport source (output valid, kind, new_ray, is_region, region_index, air_code,
                    column_index, input ready);
    modport sink   (input valid, kind, new_ray, is_region, region_index, air_code,
                    column_index, output ready);
endinterface

interface rtt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        tallied;
    logic [rtt_pkg::IDX_W-1:0]   source_region;
    logic                        no_source;
    logic [rtt_pkg::VALUE_W-1:0] read_value;

    modport source (output valid, tallied, source_region, no_source, read_value,
                    input ready);
    modport sink   (input valid, tallied, source_region, no_source, read_value,
                     output ready);
endinterface
`default_nettype wire

### design/rtt_medium.sv
// Medium tracker: current medium and source region of the ray in flight.
`default_nettype none
module rtt_medium #(
    parameter int REGIONS = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_step,
    input  wire                          i_new_ray,
    input  wire                          i_is_region,
    input  wire [rtt_pkg::IDX_W-1:0]     i_region_index,
    input  wire [rtt_pkg::AIR_W-1:0]     i_air_code,
    output rtt_pkg::t_decision           o_dec
);

    logic [rtt_pkg::AIR_W-1:0] r_medium, n_medium;
    logic                      r_src_valid, n_src_valid;
    logic [rtt_pkg::IDX_W-1:0] r_src_idx, n_src_idx;

    logic [rtt_pkg::AIR_W-1:0] eff_medium;
    logic                      eff_valid;
    logic [rtt_pkg::IDX_W-1:0] eff_idx;
    logic                      from_engine;
    logic                      both_in_range;

    always_comb begin
        // a new ray starts in exterior air with no source
        eff_medium    = i_new_ray ? rtt_pkg::MED_EXTERIOR : r_medium;
        eff_valid     = i_new_ray ? 1'b0 : r_src_valid;
        eff_idx       = i_new_ray ? '0 : r_src_idx;
        from_engine   = (eff_medium == rtt_pkg::MED_ENGINE);
        both_in_range = (32'(eff_idx) < REGIONS) && (32'(i_region_index) < REGIONS);

        o_dec.tally     = i_is_region && from_engine && eff_valid && both_in_range;
        o_dec.no_source = i_is_region && from_engine && !eff_valid;
        o_dec.src       = o_dec.tally ? eff_idx : '0;

        n_medium    = eff_medium;
        n_src_valid = eff_valid;
        n_src_idx   = eff_idx;
        if (i_is_region) begin
            n_medium    = rtt_pkg::MED_REGION;
            n_src_valid = 1'b1;
            n_src_idx   = i_region_index;
        end else if (!from_engine) begin
            n_medium = i_air_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_medium    <= rtt_pkg::MED_EXTERIOR;
            r_src_valid <= 1'b0;
            r_src_idx   <= '0;
        end else if (i_step) begin
            r_medium    <= n_medium;
            r_src_valid <= n_src_valid;
            r_src_idx   <= n_src_idx;
        end
    end

endmodule
`default_nettype wire

### design/region_transition_tally.sv
// Top level of the region transition tally: medium tracking and saturating count memories.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------------
//  i_in     | in        | kind, new_ray, is_region, region_index, air_code, column_index
//  o_out    | out       | tallied, source_region, no_source, read_value
//
// Each item: the accept cycle issues the registered reads of the leave and intercept
// memories, then the write-back stage modifies and writes back the counts and loads
// the result register. After reset a clearing pass zeroes both memories, one
// intercept entry a cycle, with i_in.ready held low. A result waiting in the output
// register does not stop the next item being taken; the write-back stage holds until
// the output register is free, and no new item is taken while it holds.
`default_nettype none
module region_transition_tally #(
    parameter int REGIONS     = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rtt_in_if.sink     i_in,
    rtt_out_if.source  o_out
);

    // only the first 64 regions can ever be addressed by a 6-bit index
    localparam int USED       = (REGIONS < 64) ? REGIONS : 64;
    localparam int AW         = $clog2(USED);
    localparam int LEAVE_DEPTH = 1 << AW;
    localparam int ICPT_DEPTH  = 1 << (2 * AW);

    typedef logic [COUNT_WIDTH-1:0] t_count;

    function automatic t_count sat_inc(input t_count c);
        return (&c) ? c : c + t_count'(1);
    endfunction

    // ---------------------------------------------------------------- accept side
    logic accept;
    logic seg_step;
    rtt_pkg::t_decision dec;

    logic r_clearing;
    logic [2*AW-1:0] r_clr_addr;
    logic r_pend;

    assign i_in.ready = !r_clearing && !r_pend;
    assign accept     = i_in.valid && i_in.ready;
    assign seg_step   = accept && (i_in.kind == rtt_pkg::KIND_SEGMENT);

    rtt_medium #(
        .REGIONS (REGIONS)
    ) u_medium (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (seg_step),
        .i_new_ray      (i_in.new_ray),
        .i_is_region    (i_in.is_region),
        .i_region_index (i_in.region_index),
        .i_air_code     (i_in.air_code),
        .o_dec          (dec)
    );

    logic row_ok, col_ok;
    assign row_ok = 32'(i_in.region_index) < REGIONS;
    assign col_ok = 32'(i_in.column_index) < REGIONS;

    // read addresses: a tally touches the source row, a read the requested entry
    logic [AW-1:0]   rd_leave_addr;
    logic [2*AW-1:0] rd_icpt_addr;
    always_comb begin
        if (seg_step && dec.tally) begin
            rd_leave_addr = dec.src[AW-1:0];
            rd_icpt_addr  = {dec.src[AW-1:0], i_in.region_index[AW-1:0]};
        end else begin
            rd_leave_addr = i_in.region_index[AW-1:0];
            rd_icpt_addr  = {i_in.region_index[AW-1:0], i_in.column_index[AW-1:0]};
        end
    end

    // ---------------------------------------------------------------- pending item
    logic                      r_p_tally, r_p_nosrc;
    logic [rtt_pkg::IDX_W-1:0] r_p_src;
    logic                      r_p_rd_leave, r_p_rd_icpt, r_p_rd_miss;
    logic [AW-1:0]             r_p_leave_addr;
    logic [2*AW-1:0]           r_p_icpt_addr;
    logic                      wb_fire;

    logic r_out_valid;
    assign wb_fire = r_pend && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= 1'b1;
        end else if (wb_fire) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_tally      <= seg_step && dec.tally;
            r_p_nosrc      <= seg_step && dec.no_source;
            r_p_src        <= seg_step ? dec.src : '0;
            r_p_rd_leave   <= (i_in.kind == rtt_pkg::KIND_READ_LEAVE) && row_ok;
            r_p_rd_icpt    <= (i_in.kind == rtt_pkg::KIND_READ_ICPT) && row_ok && col_ok;
            r_p_rd_miss    <= (i_in.kind == rtt_pkg::KIND_READ_MISS);
            r_p_leave_addr <= rd_leave_addr;
            r_p_icpt_addr  <= rd_icpt_addr;
        end
    end

    // ---------------------------------------------------------------- miss count
    t_count r_miss;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
        end else if (accept && (i_in.kind == rtt_pkg::KIND_MISS)) begin
            r_miss <= sat_inc(r_miss);
        end
    end

    // ---------------------------------------------------------------- clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- count memories
    t_count r_leave_mem [LEAVE_DEPTH];
    t_count r_icpt_mem  [ICPT_DEPTH];
    t_count r_leave_rd, r_icpt_rd;

    logic            leave_we, icpt_we;
    logic [AW-1:0]   leave_waddr;
    logic [2*AW-1:0] icpt_waddr;
    t_count          leave_wdata, icpt_wdata;

    always_comb begin
        if (r_clearing) begin
            leave_we    = 1'b1;
            icpt_we     = 1'b1;
            leave_waddr = r_clr_addr[AW-1:0];
            icpt_waddr  = r_clr_addr;
            leave_wdata = '0;
            icpt_wdata  = '0;
        end else begin
            leave_we    = wb_fire && r_p_tally;
            icpt_we     = wb_fire && r_p_tally;
            leave_waddr = r_p_leave_addr;
            icpt_waddr  = r_p_icpt_addr;
            leave_wdata = sat_inc(r_leave_rd);
            icpt_wdata  = sat_inc(r_icpt_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave_we) begin
            r_leave_mem[leave_waddr] <= leave_wdata;
        end
        if (accept) begin
            r_leave_rd <= r_leave_mem[rd_leave_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (icpt_we) begin
            r_icpt_mem[icpt_waddr] <= icpt_wdata;
        end
        if (accept) begin
            r_icpt_rd <= r_icpt_mem[rd_icpt_addr];
        end
    end

    // ---------------------------------------------------------------- result register
    t_count      sel_count;
    logic [63:0] sel_ext;
    always_comb begin
        priority if (r_p_rd_leave) begin
            sel_count = r_leave_rd;
        end else if (r_p_rd_icpt) begin
            sel_count = r_icpt_rd;
        end else if (r_p_rd_miss) begin
            sel_count = r_miss;
        end else begin
            sel_count = '0;
        end
        sel_ext = 64'(sel_count);
    end

    logic                        r_out_tallied, r_out_nosrc;
    logic [rtt_pkg::IDX_W-1:0]   r_out_src;
    logic [rtt_pkg::VALUE_W-1:0] r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            r_out_tallied <= r_p_tally;
            r_out_nosrc   <= r_p_nosrc;
            r_out_src     <= r_p_src;
            r_out_value   <= sel_ext[rtt_pkg::VALUE_W-1:0];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tallied       = r_out_tallied;
    assign o_out.source_region = r_out_src;
    assign o_out.no_source     = r_out_nosrc;
    assign o_out.read_value    = r_out_value;

endmodule
`default_nettype wire
